### hdl/slru_pkg.sv
// Package for the segmented-LRU replacement block: transfer types and fixed codes.
`default_nettype none
package slru_pkg;

	localparam int SET_IDX_W = 6;
	localparam int WAY_IDX_W = 4;
	localparam int NOW_W     = 32;

	localparam logic ACT_VICTIM = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [SET_IDX_W-1:0] set_index;
		logic [WAY_IDX_W-1:0] way_index;
		logic                 was_hit;
		logic [NOW_W-1:0]     now;
	} slru_req_t;

	typedef struct packed {
		logic [WAY_IDX_W-1:0] victim_way;
		logic                 fallback_used;
	} slru_rsp_t;

	typedef struct packed {
		logic take_en;
		logic first;
	} slru_pick_ctl_t;

endpackage
`default_nettype wire

### hdl/slru_pick.sv
// Shared compare unit that keeps the best victim candidate seen during a set scan.
`default_nettype none
module slru_pick
	import slru_pkg::*;
#(
	parameter int LVL_W      = 2,
	parameter int STAMP_BITS = 32,
	parameter int WAY_W      = 4
) (
	input  wire logic                  clk,
	input  wire slru_pick_ctl_t        ctl,
	input  wire logic [LVL_W-1:0]      lvl,
	input  wire logic [STAMP_BITS-1:0] stamp,
	input  wire logic [WAY_W-1:0]      way,
	output logic      [WAY_W-1:0]      best_way,
	output logic      [LVL_W-1:0]      best_lvl
);

	logic [STAMP_BITS-1:0] best_stamp_q;
	logic [LVL_W-1:0]      best_lvl_q;
	logic [WAY_W-1:0]      best_way_q;
	logic                  better;

	// Level first, then age; a strict compare keeps the lower way on a tie.
	assign better = ctl.first || ({lvl, stamp} < {best_lvl_q, best_stamp_q});

	always_ff @(posedge clk) begin
		if (ctl.take_en && better) begin
			best_lvl_q   <= lvl;
			best_stamp_q <= stamp;
			best_way_q   <= way;
		end
	end

	assign best_way = best_way_q;
	assign best_lvl = best_lvl_q;

endmodule
`default_nettype wire

### hdl/segmented_lru_replacement.sv
// Top level of the segmented-LRU replacement block with its per-way state memory.
`default_nettype none
// Segmented-LRU replacement state for a SETS-set, WAYS-way cache. Each way of each set holds
// a segment level and a last-use timestamp in one memory word. An update transfer stores the
// timestamp and either raises the level by one (hit, saturating at SEGMENTS-1) or clears it
// (miss fill); an update naming a way >= WAYS changes nothing. A victim transfer scans the
// set one way per cycle through a single shared compare unit and returns the oldest way at the
// lowest level present, the lower way winning a tie, with fallback_used set when that level is
// not zero. Set indexes wrap modulo SETS. An update reads its word when it is accepted and
// writes it back in the update state; a victim query reads the ways in turn on the single
// read port, then passes a drain state and a result state; the result waits in an output
// register, and a query that finds it still full holds until it drains. After reset the
// block clears all SETS*WAYS words one word a cycle and takes no request until it is done.
module segmented_lru_replacement
	import slru_pkg::*;
#(
	parameter int SETS       = 64,
	parameter int WAYS       = 16,
	parameter int SEGMENTS   = 4,
	parameter int STAMP_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire slru_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output slru_rsp_t      rsp
);

	localparam int DEPTH     = SETS * WAYS;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W     = $clog2(WAYS);
	localparam int LVL_W     = $clog2(SEGMENTS);
	localparam int WORD_W    = LVL_W + STAMP_BITS;
	localparam int SET_MAP_N = 2 ** SET_IDX_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [ADDR_W-1:0] clr_q;

	// Request address decode. The set index is folded modulo SETS by a constant table.
	logic [SET_W-1:0] set_map [SET_MAP_N];
	for (genvar g = 0; g < SET_MAP_N; g++) begin : g_set_map
		assign set_map[g] = SET_W'(g % SETS);
	end

	logic [SET_W-1:0]  set_mod;
	logic [ADDR_W-1:0] req_base;
	logic [ADDR_W-1:0] req_addr;
	logic              way_ok;
	logic              accept;
	logic              acc_upd;
	logic              acc_vic;

	assign set_mod  = set_map[req.set_index];
	assign req_base = ADDR_W'(ADDR_W'(set_mod) * ADDR_W'(WAYS));
	assign way_ok   = 32'(req.way_index) < WAYS;
	assign req_addr = (req.action == ACT_UPDATE) ? req_base + ADDR_W'(req.way_index)
	                                             : req_base;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign acc_upd   = accept && (req.action == ACT_UPDATE) && way_ok;
	assign acc_vic   = accept && (req.action == ACT_VICTIM);

	// Per-request working registers. For an update base_q holds the word address itself.
	logic [ADDR_W-1:0]     base_q;
	logic [WAY_W-1:0]      way_q;
	logic                  hit_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  dv_q;
	logic [WAY_W-1:0]      dway_q;

	// State memory: one word per set and way, level above timestamp.
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign rd_en   = acc_upd || acc_vic || (state_q == ST_SCAN);
	assign rd_addr = (state_q == ST_SCAN) ? base_q + ADDR_W'(way_q) : req_addr;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	logic [LVL_W-1:0]      rd_lvl;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [LVL_W-1:0]      new_lvl;

	assign rd_lvl   = rd_data[WORD_W-1 -: LVL_W];
	assign rd_stamp = rd_data[STAMP_BITS-1:0];

	// A hit climbs one segment until the top one; a miss fill starts again at the bottom.
	always_comb begin
		if (!hit_q) begin
			new_lvl = '0;
		end else if (rd_lvl < LVL_W'(SEGMENTS - 1)) begin
			new_lvl = rd_lvl + LVL_W'(1);
		end else begin
			new_lvl = rd_lvl;
		end
	end

	// The clearing pass and the update write-back share the single write port.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = (state_q == ST_UPD);
			wr_addr = base_q;
			wr_data = {new_lvl, stamp_q};
		end
	end

	// Scan compare unit: fed one way per cycle as read data returns.
	slru_pick_ctl_t   pick_ctl;
	logic [WAY_W-1:0] best_way;
	logic [LVL_W-1:0] best_lvl;

	assign pick_ctl.take_en = dv_q;
	assign pick_ctl.first   = (dway_q == '0);

	slru_pick #(
		.LVL_W      (LVL_W),
		.STAMP_BITS (STAMP_BITS),
		.WAY_W      (WAY_W)
	) u_pick (
		.clk      (clk),
		.ctl      (pick_ctl),
		.lvl      (rd_lvl),
		.stamp    (rd_stamp),
		.way      (dway_q),
		.best_way (best_way),
		.best_lvl (best_lvl)
	);

	logic rsp_load;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid || rsp_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			way_q   <= '0;
			dv_q    <= 1'b0;
			dway_q  <= '0;
		end else begin
			dv_q   <= acc_vic || (state_q == ST_SCAN);
			dway_q <= (state_q == ST_SCAN) ? way_q : '0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					way_q <= WAY_W'(1);
					if (acc_upd) begin
						state_q <= ST_UPD;
					end else if (acc_vic) begin
						state_q <= ST_SCAN;
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					way_q <= way_q + WAY_W'(1);
					if (way_q == WAY_W'(WAYS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= req_addr;
			hit_q   <= req.was_hit;
			stamp_q <= STAMP_BITS'(req.now);
		end
	end

	// Output register: the result stays here until its transfer completes.
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.victim_way    <= WAY_IDX_W'(best_way);
			rsp.fallback_used <= (best_lvl != '0);
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire
